// ===== rtl/padded_length_prefixed_deframer_defines.svh =====
// assertion macros for the padded length-prefixed deframer
`ifndef PADDED_LENGTH_PREFIXED_DEFRAMER_DEFINES_SVH
`define PADDED_LENGTH_PREFIXED_DEFRAMER_DEFINES_SVH

// same-cycle implication
`define PLD_ASSERT_NOW(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("pld assertion failed");

// next-cycle implication
`define PLD_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("pld assertion failed");

`endif

// ===== rtl/pld_pkg.sv =====
// shared types and constants for the padded length-prefixed deframer
`default_nettype none

package pld_pkg;

    localparam int MAX_FRAME_DEF = 16384;
    localparam int CFG_W         = 15;
    localparam int PLEN_W        = 15;
    localparam int HDR_BYTES     = 4;

    localparam logic [CFG_W-1:0] MAX_BODY_RESET = 15'd16384;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERSIZE = 2'd1;
    localparam logic [1:0] ST_BADPAD   = 2'd2;
    localparam logic [1:0] ST_SINKFULL = 2'd3;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       link_restart;
        logic       sink_full;
    } in_t;

    typedef struct packed {
        logic              byte_valid;
        logic [7:0]        data_byte;
        logic              frame_done;
        logic [PLEN_W-1:0] payload_len;
        logic [1:0]        frame_status;
    } out_t;

endpackage

`default_nettype wire

// ===== rtl/pld_in_stage.sv =====
// input register of the deframer
`default_nettype none

module pld_in_stage (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire pld_pkg::in_t  s_data,
    input  wire logic          advance,
    output logic               item_valid,
    output pld_pkg::in_t       item
);

    logic         valid_reg;
    logic         valid_next;
    pld_pkg::in_t data_reg;

    assign s_ready    = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pld_parser.sv =====
// frame parser: header assembly, body forwarding and padding check
`default_nettype none
`include "padded_length_prefixed_deframer_defines.svh"

module pld_parser #(
    parameter int MAX_FRAME = pld_pkg::MAX_FRAME_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_we,
    input  wire logic [pld_pkg::CFG_W-1:0] cfg_value,
    input  wire logic                      advance,
    input  wire pld_pkg::in_t              item,
    output logic                           produce,
    output pld_pkg::out_t                  result
);

    localparam int LIM_CAP = (MAX_FRAME < 32767) ? MAX_FRAME : 32767;
    localparam int LEN_W   = $clog2(LIM_CAP + 1);
    localparam logic [pld_pkg::CFG_W-1:0] LIM_CAP_V = pld_pkg::CFG_W'(LIM_CAP);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_BODY,
        PH_DEAD
    } phase_t;

    phase_t                     phase_reg, phase_next;
    logic [1:0]                 cnt_reg, cnt_next;
    logic [23:0]                hdr_reg, hdr_next;
    logic [LEN_W-1:0]           len_reg, len_next;
    logic [LEN_W-1:0]           rem_reg, rem_next;
    logic [15:0]                tail_reg, tail_next;
    logic [pld_pkg::CFG_W-1:0]  max_len_reg;

    logic [pld_pkg::CFG_W-1:0]  limit;
    logic [31:0]                full_len;
    logic [15:0]                tail_new;
    logic [15:0]                len16;
    logic [15:0]                len_m2;
    logic [15:0]                plen16;
    logic                       bad_pad;

    assign limit    = (max_len_reg > LIM_CAP_V) ? LIM_CAP_V : max_len_reg;
    assign full_len = {item.rx_byte, hdr_reg};
    assign tail_new = {item.rx_byte, tail_reg[15:8]};
    assign len16    = 16'(len_reg);
    assign len_m2   = len16 - 16'd2;
    assign bad_pad  = (len16 >= 16'd2) && (tail_new > len_m2);
    assign plen16   = (len16 >= 16'd2) ? (len_m2 - tail_new) : len16;

    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        hdr_next   = hdr_reg;
        len_next   = len_reg;
        rem_next   = rem_reg;
        tail_next  = tail_reg;
        produce    = 1'b0;
        result     = '0;
        if (advance) begin
            if (item.link_restart) begin
                phase_next = PH_HEADER;
                cnt_next   = '0;
                hdr_next   = '0;
                len_next   = '0;
                rem_next   = '0;
                tail_next  = '0;
            end else begin
                unique case (phase_reg)
                    PH_HEADER: begin
                        hdr_next = {item.rx_byte, hdr_reg[23:8]};
                        cnt_next = cnt_reg + 2'd1;
                        if (cnt_reg == 2'(pld_pkg::HDR_BYTES - 1)) begin
                            hdr_next = '0;
                            if (full_len > 32'(limit)) begin
                                phase_next          = PH_DEAD;
                                produce             = 1'b1;
                                result.frame_done   = 1'b1;
                                result.frame_status = pld_pkg::ST_OVERSIZE;
                            end else if (full_len == 32'd0) begin
                                produce           = 1'b1;
                                result.frame_done = 1'b1;
                                if (item.sink_full) begin
                                    phase_next          = PH_DEAD;
                                    result.frame_status = pld_pkg::ST_SINKFULL;
                                end
                            end else begin
                                phase_next = PH_BODY;
                                len_next   = full_len[LEN_W-1:0];
                                rem_next   = full_len[LEN_W-1:0];
                                tail_next  = '0;
                            end
                        end
                    end
                    PH_BODY: begin
                        tail_next         = tail_new;
                        rem_next          = rem_reg - LEN_W'(1);
                        produce           = 1'b1;
                        result.byte_valid = 1'b1;
                        result.data_byte  = item.rx_byte;
                        if (rem_reg == LEN_W'(1)) begin
                            result.frame_done = 1'b1;
                            if (bad_pad) begin
                                phase_next          = PH_DEAD;
                                result.frame_status = pld_pkg::ST_BADPAD;
                            end else if (item.sink_full) begin
                                phase_next          = PH_DEAD;
                                result.frame_status = pld_pkg::ST_SINKFULL;
                            end else begin
                                result.payload_len = pld_pkg::PLEN_W'(plen16[LEN_W-1:0]);
                                phase_next         = PH_HEADER;
                                cnt_next           = '0;
                                hdr_next           = '0;
                                len_next           = '0;
                                rem_next           = '0;
                                tail_next          = '0;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HEADER;
            cnt_reg     <= '0;
            hdr_reg     <= '0;
            len_reg     <= '0;
            rem_reg     <= '0;
            tail_reg    <= '0;
            max_len_reg <= pld_pkg::MAX_BODY_RESET;
        end else begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            hdr_reg   <= hdr_next;
            len_reg   <= len_next;
            rem_reg   <= rem_next;
            tail_reg  <= tail_next;
            if (cfg_we) begin
                max_len_reg <= cfg_value;
            end
        end
    end

    `PLD_ASSERT_NOW(a_dead_quiet, aclk, aresetn,
        advance && phase_reg == PH_DEAD && !item.link_restart, !produce)
    `PLD_ASSERT_NEXT(a_ok_rearms, aclk, aresetn,
        produce && result.frame_done && result.frame_status == pld_pkg::ST_OK,
        phase_reg == PH_HEADER && cnt_reg == 2'd0)
    `PLD_ASSERT_NEXT(a_error_dead, aclk, aresetn,
        produce && result.frame_done && result.frame_status != pld_pkg::ST_OK,
        phase_reg == PH_DEAD)

endmodule

`default_nettype wire

// ===== rtl/pld_out_stage.sv =====
// result register of the deframer
`default_nettype none

module pld_out_stage (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          load,
    input  wire pld_pkg::out_t res,
    output logic               free,
    output logic               m_valid,
    input  wire logic          m_ready,
    output pld_pkg::out_t      m_data
);

    logic          valid_reg;
    logic          valid_next;
    pld_pkg::out_t data_reg;

    assign free    = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign m_data  = data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (load) begin
            data_reg <= res;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/padded_length_prefixed_deframer.sv =====
// Padded length-prefixed deframer. Each received byte passes through an input
// register, one parser update and a result register, so one byte is taken per
// clock and its result is then presented by the result register; the rate is
// set by the single parser state update per byte, and the input stalls only
// while the result register holds a result the sink has not yet taken. A
// frame is a 4-byte little-endian body length followed by the body; every body
// byte is passed on and the last one also carries the payload length with
// padding stripped. An oversize length, a bad padding count or a full sink at
// the end of a frame reports an error and the parser stays dead until an item
// with link_restart set. The length limit register may be written at any time
// the block is idle; cfg_ready is always high and the new limit applies to the
// next header.
`default_nettype none

module padded_length_prefixed_deframer #(
    parameter int MAX_FRAME = pld_pkg::MAX_FRAME_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire pld_pkg::in_t              s_data,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output pld_pkg::out_t                  m_data,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [pld_pkg::CFG_W-1:0] cfg_data
);

    logic          item_valid;
    pld_pkg::in_t  item;
    logic          out_free;
    logic          advance;
    logic          produce;
    pld_pkg::out_t res;

    assign cfg_ready = 1'b1;
    assign advance   = item_valid && out_free;

    pld_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    pld_parser #(
        .MAX_FRAME (MAX_FRAME)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_value (cfg_data),
        .advance   (advance),
        .item      (item),
        .produce   (produce),
        .result    (res)
    );

    pld_out_stage u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (advance && produce),
        .res     (res),
        .free    (out_free),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

// ===== sim/tb_padded_length_prefixed_deframer.sv =====
// self-checking testbench for the padded length-prefixed deframer
`timescale 1ns / 100ps

module tb_padded_length_prefixed_deframer;

    localparam int QUIET_LIMIT = 2000;
    localparam int STALL_CYCLES = 300;
    localparam int N_DIR = 24;

    typedef enum logic [1:0] {PH_HDR, PH_BODY, PH_DEAD} parse_phase_t;

    typedef struct packed {
        pld_pkg::in_t  item;
        logic          pin;
        pld_pkg::out_t res;
    } dir_row_t;

    logic aclk;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    pld_pkg::in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    pld_pkg::out_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [pld_pkg::CFG_W-1:0] cfg_data = '0;

    // typed-in expectation travelling with a directed transfer
    logic s_pin = 1'b0;
    pld_pkg::out_t s_pin_res = '0;

    // predictor state
    parse_phase_t p_phase;
    logic [1:0]  p_hdr_cnt;
    logic [31:0] p_len;
    logic [14:0] p_left;
    logic [15:0] p_tail;
    logic [pld_pkg::CFG_W-1:0] p_max_body;

    pld_pkg::out_t deframed_q[$];
    dir_row_t dir_rows[0:N_DIR-1];
    int n_dir = 0;

    bit gaps_on = 1'b1;
    int stall_requests = 0;
    int stall_served = 0;
    int stall_left = 0;
    int quiet = 0;
    int stream_items = 0;
    int n_err = 0, n_in = 0, n_out = 0, n_cfg = 0;
    int n_ok = 0, n_over = 0, n_badpad = 0, n_sink = 0;

    padded_length_prefixed_deframer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic pld_pkg::in_t mk_in(logic [7:0] b, logic rst, logic snk);
        return {b, rst, snk};
    endfunction

    function automatic pld_pkg::out_t mk_res(logic v, logic [7:0] d, logic done,
                                             logic [pld_pkg::PLEN_W-1:0] plen,
                                             logic [1:0] st);
        return {v, d, done, plen, st};
    endfunction

    function automatic logic [31:0] cur_limit();
        if (32'(p_max_body) > 32'(pld_pkg::MAX_FRAME_DEF))
            return 32'(pld_pkg::MAX_FRAME_DEF);
        return 32'(p_max_body);
    endfunction

    task automatic reset_parser();
        p_phase = PH_HDR;
        p_hdr_cnt = 2'd0;
        p_len = 32'd0;
        p_left = 15'd0;
        p_tail = 16'd0;
    endtask

    task automatic finish_frame(input logic snk, output logic [1:0] st,
                                output logic [pld_pkg::PLEN_W-1:0] plen);
        logic [31:0] keep;
        keep = p_len;
        plen = '0;
        if (p_len >= 32'd2) begin
            if (32'(p_tail) > p_len - 32'd2) begin
                st = pld_pkg::ST_BADPAD;
                p_phase = PH_DEAD;
                return;
            end
            keep = p_len - 32'd2 - 32'(p_tail);
        end
        if (snk) begin
            st = pld_pkg::ST_SINKFULL;
            p_phase = PH_DEAD;
            return;
        end
        st = pld_pkg::ST_OK;
        plen = keep[pld_pkg::PLEN_W-1:0];
        reset_parser();
    endtask

    task automatic deframe_byte(input pld_pkg::in_t it, output bit has_res,
                                output pld_pkg::out_t res);
        logic [31:0] lim;
        logic [1:0] st;
        logic [pld_pkg::PLEN_W-1:0] plen;
        has_res = 1'b0;
        res = '0;
        if (it.link_restart) begin
            reset_parser();
            return;
        end
        case (p_phase)
            PH_HDR: begin
                p_len = p_len | (32'(it.rx_byte) << (8 * int'(p_hdr_cnt)));
                p_hdr_cnt = p_hdr_cnt + 2'd1;
                if (p_hdr_cnt == 2'd0) begin
                    lim = cur_limit();
                    if (p_len > lim) begin
                        p_phase = PH_DEAD;
                        has_res = 1'b1;
                        res = mk_res(1'b0, 8'h00, 1'b1, '0, pld_pkg::ST_OVERSIZE);
                    end else if (p_len == 32'd0) begin
                        finish_frame(it.sink_full, st, plen);
                        has_res = 1'b1;
                        res = mk_res(1'b0, 8'h00, 1'b1, plen, st);
                    end else begin
                        p_phase = PH_BODY;
                        p_left = p_len[14:0];
                        p_tail = 16'd0;
                    end
                end
            end
            PH_BODY: begin
                p_tail = {it.rx_byte, p_tail[15:8]};
                p_left = p_left - 15'd1;
                has_res = 1'b1;
                if (p_left != 15'd0) begin
                    res = mk_res(1'b1, it.rx_byte, 1'b0, '0, pld_pkg::ST_OK);
                end else begin
                    finish_frame(it.sink_full, st, plen);
                    res = mk_res(1'b1, it.rx_byte, 1'b1, plen, st);
                end
            end
            default: begin
            end
        endcase
    endtask

    // transfer monitor and scoreboard
    always @(posedge aclk) begin : monitor
        bit has;
        pld_pkg::out_t pr;
        pld_pkg::out_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                p_max_body = cfg_data;
                n_cfg++;
            end
            if (s_valid && s_ready) begin
                deframe_byte(s_data, has, pr);
                n_in++;
                if (s_pin)
                    deframed_q = {deframed_q, s_pin_res};
                else if (has)
                    deframed_q = {deframed_q, pr};
            end
            if (m_valid && m_ready) begin
                n_out++;
                if (deframed_q.size() == 0) begin
                    n_err++;
                    $display("%0t: unexpected result, actual valid=%0b byte=%02h",
                             $time, m_data.byte_valid, m_data.data_byte);
                    $display("%0t:   done=%0b len=%0d st=%0d", $time,
                             m_data.frame_done, m_data.payload_len, m_data.frame_status);
                end else begin
                    want = deframed_q.pop_front();
                    if (m_data !== want) begin
                        n_err++;
                        $display("%0t: mismatch, expected valid=%0b byte=%02h done=%0b len=%0d st=%0d",
                                 $time, want.byte_valid, want.data_byte, want.frame_done,
                                 want.payload_len, want.frame_status);
                        $display("%0t:  actual valid=%0b byte=%02h done=%0b len=%0d st=%0d",
                                 $time, m_data.byte_valid, m_data.data_byte, m_data.frame_done,
                                 m_data.payload_len, m_data.frame_status);
                    end
                    if (want.frame_done) begin
                        case (want.frame_status)
                            pld_pkg::ST_OK:       n_ok++;
                            pld_pkg::ST_OVERSIZE: n_over++;
                            pld_pkg::ST_BADPAD:   n_badpad++;
                            default:              n_sink++;
                        endcase
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT) begin
                $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                         $time, QUIET_LIMIT, deframed_q.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // result side back-pressure
    always @(negedge aclk) begin
        if (stall_left == 0 && stall_served != stall_requests) begin
            stall_served = stall_requests;
            stall_left = STALL_CYCLES;
        end
        if (stall_left != 0) begin
            stall_left = stall_left - 1;
            m_ready <= 1'b0;
        end else if (gaps_on) begin
            m_ready <= ($urandom_range(99) >= 13);
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send_item(input pld_pkg::in_t it, input logic pin, input pld_pkg::out_t res);
        while (gaps_on && $urandom_range(99) < 13) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        s_pin <= pin;
        s_pin_res <= res;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_restart();
        send_item(mk_in(8'($urandom), 1'b1, 1'($urandom_range(1))), 1'b0, '0);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (deframed_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_limit(input logic [pld_pkg::CFG_W-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // one frame: header, body with padding count in the last two bytes;
    // cut >= 0 aborts it with a restart before that byte
    task automatic send_frame(input logic [31:0] len, input bit bad_pad, input bit sink_end,
                              input int cut);
        int i;
        logic [15:0] pad;
        logic [7:0] b;
        pad = 16'd0;
        if (len >= 32'd2 && len <= 32'(pld_pkg::MAX_FRAME_DEF)) begin
            if (!bad_pad)
                pad = 16'($urandom_range(int'(len) - 2, 0));
            else if ($urandom_range(1) != 0)
                pad = 16'(len - 32'd1);
            else
                pad = 16'($urandom_range(65535, int'(len) - 1));
        end
        for (i = 0; i < 4; i++) begin
            if (cut == i) begin
                send_restart();
                return;
            end
            send_item(mk_in(len[8*i +: 8], 1'b0,
                            (i == 3 && len == 32'd0) ? sink_end : 1'($urandom_range(1))),
                      1'b0, '0);
            stream_items++;
        end
        if (p_phase != PH_BODY)
            return;
        for (i = 0; i < int'(len); i++) begin
            if (cut == i + 4) begin
                send_restart();
                return;
            end
            if (len >= 32'd2 && i == int'(len) - 2)
                b = pad[7:0];
            else if (len >= 32'd2 && i == int'(len) - 1)
                b = pad[15:8];
            else
                b = 8'($urandom);
            send_item(mk_in(b, 1'b0, (i == int'(len) - 1) ? sink_end : 1'($urandom_range(1))),
                      1'b0, '0);
            stream_items++;
        end
    endtask

    task automatic recover();
        if (p_phase == PH_DEAD) begin
            repeat ($urandom_range(2))
                send_item(mk_in(8'($urandom), 1'b0, 1'($urandom_range(1))), 1'b0, '0);
            send_restart();
        end
    endtask

    task automatic random_frame();
        int r;
        int n;
        logic [31:0] len;
        logic [31:0] lim;
        lim = cur_limit();
        n = $urandom_range(99);
        if (n < 10)
            len = 32'd0;
        else if (n < 65)
            len = 32'($urandom_range(12, 1));
        else if (n < 85)
            len = 32'($urandom_range(40, 13));
        else if (n < 93 && lim <= 32'd64)
            len = lim + 32'($urandom_range(1));
        else if (n < 93)
            len = 32'($urandom_range(100, 41));
        else
            len = $urandom;
        r = $urandom_range(99);
        if (r < 84) begin
            send_frame(len, $urandom_range(99) < 12, $urandom_range(99) < 8, -1);
        end else if (r < 93) begin
            send_frame(len, $urandom_range(99) < 12, $urandom_range(99) < 8,
                       $urandom_range(3 + ((len > 32'd100) ? 100 : int'(len)), 0));
        end else begin
            repeat ($urandom_range(3, 1))
                send_item(mk_in(8'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1))),
                          1'b0, '0);
            send_restart();
        end
        recover();
    endtask

    task automatic add_row(input logic [7:0] b, input logic rst, input logic snk,
                           input logic pin, input pld_pkg::out_t res);
        dir_rows[n_dir] = {mk_in(b, rst, snk), pin, res};
        n_dir++;
    endtask

    initial begin
        int i;
        p_max_body = pld_pkg::MAX_BODY_RESET;
        reset_parser();

        // zero length with a full sink, then bytes ignored while dead
        add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b1, 1'b1,
                mk_res(1'b0, 8'h00, 1'b1, '0, pld_pkg::ST_SINKFULL));
        add_row(8'hff, 1'b0, 1'b1, 1'b0, '0);
        add_row(8'hff, 1'b1, 1'b1, 1'b0, '0);
        // one above the reset limit
        add_row(8'h01, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h40, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b1, 1'b1,
                mk_res(1'b0, 8'h00, 1'b1, '0, pld_pkg::ST_OVERSIZE));
        add_row(8'h00, 1'b1, 1'b0, 1'b0, '0);
        // single byte body passes its length unchanged
        add_row(8'h01, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'hff, 1'b0, 1'b0, 1'b1, mk_res(1'b1, 8'hff, 1'b1, 15'd1, pld_pkg::ST_OK));
        // padding count larger than the body allows
        add_row(8'h03, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'haa, 1'b0, 1'b0, 1'b1, mk_res(1'b1, 8'haa, 1'b0, '0, pld_pkg::ST_OK));
        add_row(8'h02, 1'b0, 1'b0, 1'b1, mk_res(1'b1, 8'h02, 1'b0, '0, pld_pkg::ST_OK));
        add_row(8'h00, 1'b0, 1'b0, 1'b1,
                mk_res(1'b1, 8'h00, 1'b1, '0, pld_pkg::ST_BADPAD));
        add_row(8'h55, 1'b1, 1'b0, 1'b0, '0);

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (i = 0; i < n_dir; i++)
            send_item(dir_rows[i].item, dir_rows[i].pin, dir_rows[i].res);

        while (stream_items < 240) random_frame();

        write_limit(15'd0);
        while (stream_items < 320) random_frame();

        write_limit(15'h7fff);
        gaps_on = 1'b0;
        while (stream_items < 500) random_frame();
        gaps_on = 1'b1;

        write_limit(15'($urandom_range(48, 1)));
        stall_requests++;
        while (stream_items < 700) random_frame();

        write_limit(pld_pkg::MAX_BODY_RESET);
        while (stream_items < 900) random_frame();
        // largest length the limit allows, cut short, then one byte more
        send_frame(32'd16384, 1'b0, 1'b0, 20);
        recover();
        send_frame(32'd16385, 1'b0, 1'b0, -1);
        recover();

        drain();
        repeat (12) @(posedge aclk);
        $display("%0d input transfers, %0d result transfers, %0d limit writes",
                 n_in, n_out, n_cfg);
        $display("frames: %0d ok, %0d oversize, %0d bad padding, %0d sink full, %0d errors",
                 n_ok, n_over, n_badpad, n_sink, n_err);
        if (n_err == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
